/* hdl/svs_pkg.sv */
`timescale 1ns / 1ps

package svs_pkg;

    // bone store geometry
    localparam int BONE_COUNT     = 64;
    localparam int BONE_AW        = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int BONE_IDX_W     = 6;
    localparam int BONE_IDX_RANGE = 1 << BONE_IDX_W;
    localparam int COEF_COUNT     = 12;
    localparam int SLOT_W         = 4;
    localparam int COEF_TRANS     = 9;

    // operation codes carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SKIN  = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 304;
    localparam int M_TDATA_W = 256;

    typedef logic signed [31:0]  q_t;
    typedef q_t [2:0]            vec3_t;
    typedef logic [BONE_AW-1:0]  bone_addr_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef q_t [COEF_COUNT-1:0] coef_set_t;

    // vertex payload entering the transform
    typedef struct packed {
        vec3_t       pos;
        vec3_t       norm;
        logic [63:0] tex;
        logic        last;
    } vtx_t;

    // finished result
    typedef struct packed {
        vec3_t       pos;
        vec3_t       norm;
        logic [63:0] tex;
        logic        last;
    } res_t;

    // bone index wrap table, built at elaboration
    typedef bone_addr_t bone_wrap_t [BONE_IDX_RANGE];

    function automatic bone_wrap_t build_bone_wrap();
        bone_wrap_t t;
        for (int i = 0; i < BONE_IDX_RANGE; i++) begin
            t[i] = bone_addr_t'(i % BONE_COUNT);
        end
        return t;
    endfunction

    localparam bone_wrap_t BONE_WRAP = build_bone_wrap();

endpackage

/* hdl/svs_ram.sv */
`timescale 1ns / 1ps

module svs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/svs_coef_store.sv */
`timescale 1ns / 1ps

module svs_coef_store
    import svs_pkg::*;
(
    input  logic       aclk,
    input  logic       wr_en,
    input  bone_addr_t wr_bone,
    input  slot_t      wr_slot,
    input  q_t         wr_data,
    input  logic       rd_en,
    input  bone_addr_t rd_bone,
    output coef_set_t  coefs
);

    // one bank per coefficient slot so a vertex reads all twelve at once
    for (genvar k = 0; k < COEF_COUNT; k++) begin : g_bank
        logic bank_wr;
        logic [31:0] bank_rd;

        // slots past the last bank never match, so those writes drop
        assign bank_wr = wr_en && (wr_slot == slot_t'(k));

        svs_ram #(
            .WIDTH (32),
            .DEPTH (BONE_COUNT)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_wr),
            .wr_addr (wr_bone),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_bone),
            .rd_data (bank_rd)
        );

        assign coefs[k] = q_t'(bank_rd);
    end

endmodule

/* hdl/svs_transform.sv */
`timescale 1ns / 1ps

module svs_transform
    import svs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vtx_t      in_vtx,
    input  coef_set_t in_coefs,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      out_res
);

    typedef logic signed [63:0] prod_t;
    typedef logic signed [65:0] acc_t;

    localparam logic signed [50:0] ACC_MAX = 51'sd2147483647;
    localparam logic signed [50:0] ACC_MIN = -51'sd2147483648;
    localparam q_t Q_MAX = 32'sh7FFFFFFF;
    localparam q_t Q_MIN = 32'sh80000000;

    // product stage
    typedef struct packed {
        prod_t [8:0] prod_pos;
        prod_t [8:0] prod_norm;
        vec3_t       trans;
        logic [63:0] tex;
        logic        last;
    } st2_t;

    // sum stage
    typedef struct packed {
        acc_t [2:0]  sum_pos;
        acc_t [2:0]  sum_norm;
        vec3_t       trans;
        logic [63:0] tex;
        logic        last;
    } st3_t;

    function automatic prod_t smul(q_t a, q_t b);
        prod_t p;
        p = a * b;
        return p;
    endfunction

    // floor to q16.16, add offset, clamp to 32 bits
    function automatic q_t sat_out(acc_t s, q_t t);
        logic signed [49:0] sh;
        logic signed [50:0] acc;
        sh  = s[65:16];
        acc = {sh[49], sh} + {{19{t[31]}}, t};
        if (acc > ACC_MAX) begin
            return Q_MAX;
        end else if (acc < ACC_MIN) begin
            return Q_MIN;
        end else begin
            return q_t'(acc[31:0]);
        end
    endfunction

    logic v2_reg, v2_next, v3_reg, v3_next, v4_reg, v4_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    res_t st4_reg, st4_next;
    logic rdy2, rdy3, rdy4;

    // a stage takes new data when empty or when its successor moves
    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign in_ready = rdy2;

    // valid bits
    always_comb begin
        v2_next = rdy2 ? in_valid : v2_reg;
        v3_next = rdy3 ? v2_reg   : v3_reg;
        v4_next = rdy4 ? v3_reg   : v4_reg;
    end

    // stage 2: eighteen 32x32 products
    always_comb begin
        st2_next = st2_reg;
        if (rdy2) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    st2_next.prod_pos[i*3+j]  = smul($signed(in_vtx.pos[j]),
                                                     $signed(in_coefs[j*3+i]));
                    st2_next.prod_norm[i*3+j] = smul($signed(in_vtx.norm[j]),
                                                     $signed(in_coefs[j*3+i]));
                end
                st2_next.trans[i] = in_coefs[COEF_TRANS+i];
            end
            st2_next.tex  = in_vtx.tex;
            st2_next.last = in_vtx.last;
        end
    end

    // stage 3: exact three-term sums
    always_comb begin
        st3_next = st3_reg;
        if (rdy3) begin
            for (int i = 0; i < 3; i++) begin
                st3_next.sum_pos[i]  = acc_t'($signed(st2_reg.prod_pos[i*3]))
                                     + acc_t'($signed(st2_reg.prod_pos[i*3+1]))
                                     + acc_t'($signed(st2_reg.prod_pos[i*3+2]));
                st3_next.sum_norm[i] = acc_t'($signed(st2_reg.prod_norm[i*3]))
                                     + acc_t'($signed(st2_reg.prod_norm[i*3+1]))
                                     + acc_t'($signed(st2_reg.prod_norm[i*3+2]));
            end
            st3_next.trans = st2_reg.trans;
            st3_next.tex   = st2_reg.tex;
            st3_next.last  = st2_reg.last;
        end
    end

    // stage 4: truncate, translate, saturate into the output register
    always_comb begin
        st4_next = st4_reg;
        if (rdy4) begin
            for (int i = 0; i < 3; i++) begin
                st4_next.pos[i]  = sat_out(st3_reg.sum_pos[i], $signed(st3_reg.trans[i]));
                st4_next.norm[i] = sat_out(st3_reg.sum_norm[i], '0);
            end
            st4_next.tex  = st3_reg.tex;
            st4_next.last = st3_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        st2_reg <= st2_next;
        st3_reg <= st3_next;
        st4_reg <= st4_next;
    end

    assign out_valid = v4_reg;
    assign out_res   = st4_reg;

endmodule

/* hdl/single_bone_vertex_skinning_unit.sv */
`timescale 1ns / 1ps
// a vertex beat passes the stage 1, product, sum and output registers on its way to m_tvalid
// throughput: one beat (vertex or coefficient write) per cycle while m_tready keeps the
//   output moving, set by the four-stage read / multiply / sum / saturate pipeline
// coefficient writes produce no output beat and land in the store at once
// reset clears the pipeline valid bits only; bone matrices are not cleared

module single_bone_vertex_skinning_unit
    import svs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // bone_index, coef_index, coef_value, pos_x, pos_y, pos_z,
    // norm_x, norm_y, norm_z, tex_uv, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
    // out_tex_uv
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [BONE_IDX_W-1:0] s_bone_index;
    slot_t                 s_coef_index;
    q_t                    s_coef_value;
    bone_addr_t            bone_addr;
    vtx_t                  vtx_in;

    logic      v1_reg, v1_next;
    vtx_t      vtx1_reg, vtx1_next;
    logic      rdy1, xf_ready, wr_en;
    coef_set_t coefs;
    res_t      res;

    // unpack the input beat
    assign s_bone_index = s_tdata[5:0];
    assign s_coef_index = s_tdata[9:6];
    assign s_coef_value = q_t'(s_tdata[41:10]);
    assign bone_addr    = BONE_WRAP[s_bone_index];

    always_comb begin
        vtx_in.pos[0]  = q_t'(s_tdata[73:42]);
        vtx_in.pos[1]  = q_t'(s_tdata[105:74]);
        vtx_in.pos[2]  = q_t'(s_tdata[137:106]);
        vtx_in.norm[0] = q_t'(s_tdata[169:138]);
        vtx_in.norm[1] = q_t'(s_tdata[201:170]);
        vtx_in.norm[2] = q_t'(s_tdata[233:202]);
        vtx_in.tex     = s_tdata[297:234];
        vtx_in.last    = s_tlast;
    end

    // stage 1 handshake: matrix read lines up with the vertex payload
    assign rdy1     = !v1_reg || xf_ready;
    assign s_tready = rdy1;
    assign wr_en    = s_tvalid && rdy1 && (s_tuser == OP_WRITE);

    always_comb begin
        v1_next   = v1_reg;
        vtx1_next = vtx1_reg;
        if (rdy1) begin
            v1_next   = s_tvalid && (s_tuser == OP_SKIN);
            vtx1_next = vtx_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        vtx1_reg <= vtx1_next;
    end

    svs_coef_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_bone (bone_addr),
        .wr_slot (s_coef_index),
        .wr_data (s_coef_value),
        .rd_en   (rdy1),
        .rd_bone (bone_addr),
        .coefs   (coefs)
    );

    svs_transform u_xf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (xf_ready),
        .in_vtx    (vtx1_reg),
        .in_coefs  (coefs),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the output beat
    assign m_tdata = {res.tex, res.norm[2], res.norm[1], res.norm[0],
                      res.pos[2], res.pos[1], res.pos[0]};
    assign m_tlast = res.last;

endmodule

/* hdl/svs_checker.sv */
`timescale 1ns / 1ps

module svs_checker
    import svs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic in_beat;
    assign in_beat = s_tvalid && s_tready;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // an open output lets the input through in the same cycle
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output is open");

    // idle input with an open output drains the stage 1, product, sum and output registers
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_beat && m_tready) ##1 (!in_beat && m_tready)
        ##1 (!in_beat && m_tready) ##1 (!in_beat && m_tready) |=> !m_tvalid)
        else $error("output beat without a matching input beat");

endmodule

bind single_bone_vertex_skinning_unit svs_checker u_svs_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import svs_pkg::*;

    localparam int   STALL_LIMIT  = 4000;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   DRAIN_CYCLES = 12;
    localparam int   MIX_ITEMS    = 1650;
    localparam int   MAX_PRINTS   = 40;
    localparam q_t   Q_ONE        = 32'sh0001_0000;
    localparam q_t   Q_HALF       = 32'sh0000_8000;
    localparam q_t   Q_TOP        = 32'sh7FFF_FFFF;
    localparam q_t   Q_BOTTOM     = 32'sh8000_0000;
    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    // one input beat, fields as the block sees them
    typedef struct packed {
        logic        op;
        logic [5:0]  bone;
        slot_t       slot;
        q_t          coef;
        vec3_t       pos;
        vec3_t       norm;
        logic [63:0] tex;
        logic        last;
    } beat_in_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // predictor state: coefficient store and which slots were loaded
    q_t                    bone_coef [BONE_COUNT][COEF_COUNT];
    logic [COEF_COUNT-1:0] coef_loaded [BONE_COUNT];
    int                    ready_bones [$];
    res_t                  pending_vertices [$];

    bit tx_gaps;
    bit rx_gaps;
    bit hold_req;
    int error_count;
    int beats_sent;
    int useful_beats;
    int results_seen;
    int quiet_cycles;

    single_bone_vertex_skinning_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // exact dot product, floor to q16.16, add offset, clamp to 32 bits
    function automatic q_t blend_sat(vec3_t v, q_t c0, q_t c1, q_t c2, q_t offs);
        logic signed [65:0] acc;
        acc = $signed(v[0]) * c0 + $signed(v[1]) * c1 + $signed(v[2]) * c2;
        acc = (acc >>> 16) + offs;
        if (acc > SAT_HI)
            return Q_TOP;
        if (acc < SAT_LO)
            return Q_BOTTOM;
        return q_t'(acc[31:0]);
    endfunction

    // row-vector transform by the matrix of the addressed bone
    function automatic res_t skin_vertex(beat_in_t b);
        res_t r;
        int   bi;
        bi = int'(b.bone) % BONE_COUNT;
        for (int i = 0; i < 3; i++) begin
            r.pos[i]  = blend_sat(b.pos, bone_coef[bi][i], bone_coef[bi][3 + i],
                                  bone_coef[bi][6 + i], bone_coef[bi][COEF_TRANS + i]);
            r.norm[i] = blend_sat(b.norm, bone_coef[bi][i], bone_coef[bi][3 + i],
                                  bone_coef[bi][6 + i], q_t'(0));
        end
        r.tex  = b.tex;
        r.last = b.last;
        return r;
    endfunction

    function automatic q_t rand_q();
        case ($urandom_range(0, 9))
            0: return Q_TOP;
            1: return Q_BOTTOM;
            2, 3, 4: return q_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            5: return q_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            default: return q_t'($urandom);
        endcase
    endfunction

    function automatic beat_in_t rand_beat();
        beat_in_t b;
        b.op   = OP_SKIN;
        b.bone = 6'($urandom_range(0, 63));
        b.slot = slot_t'($urandom_range(0, 15));
        b.coef = q_t'($urandom);
        for (int k = 0; k < 3; k++) begin
            b.pos[k]  = rand_q();
            b.norm[k] = rand_q();
        end
        b.tex  = {$urandom, $urandom};
        b.last = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < MAX_PRINTS)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // drive one beat, wait for the handshake, then update the prediction
    task automatic send_beat(beat_in_t b);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tlast  <= b.last;
        s_tdata  <= {6'd0, b.tex, b.norm[2], b.norm[1], b.norm[0],
                     b.pos[2], b.pos[1], b.pos[0], b.coef, b.slot, b.bone};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        beats_sent++;
        if (b.op == OP_SKIN) begin
            pending_vertices.push_back(skin_vertex(b));
            useful_beats++;
        end else if (b.slot < COEF_COUNT) begin
            bone_coef[int'(b.bone) % BONE_COUNT][b.slot] = b.coef;
            coef_loaded[int'(b.bone) % BONE_COUNT][b.slot] = 1'b1;
            useful_beats++;
        end
    endtask

    task automatic write_coef(int bone, int slot, q_t value);
        beat_in_t b;
        int       bi;
        b      = rand_beat();
        b.op   = OP_WRITE;
        b.bone = 6'(bone);
        b.slot = slot_t'(slot);
        b.coef = value;
        send_beat(b);
        bi = bone % BONE_COUNT;
        if (&coef_loaded[bi]) begin
            foreach (ready_bones[k])
                if (ready_bones[k] == bi)
                    return;
            ready_bones.push_back(bi);
        end
    endtask

    task automatic skin(int bone, q_t px, q_t py, q_t pz, q_t nx, q_t ny, q_t nz,
                        logic [63:0] tex, logic last);
        beat_in_t b;
        b      = rand_beat();
        b.op   = OP_SKIN;
        b.bone = 6'(bone);
        b.pos  = {pz, py, px};
        b.norm = {nz, ny, nx};
        b.tex  = tex;
        b.last = last;
        send_beat(b);
    endtask

    task automatic skin_random(int bone, logic last);
        beat_in_t b;
        b      = rand_beat();
        b.bone = 6'(bone);
        b.last = last;
        send_beat(b);
    endtask

    // all twelve slots of one bone, in shuffled order
    task automatic load_bone(int bone, bit narrow);
        int order [COEF_COUNT];
        int j;
        int tmp;
        q_t v;
        for (int k = 0; k < COEF_COUNT; k++)
            order[k] = k;
        for (int k = COEF_COUNT - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < COEF_COUNT; k++) begin
            v = narrow ? q_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17)) : rand_q();
            write_coef(bone, order[k], v);
        end
    endtask

    function automatic int pick_ready_bone();
        return ready_bones[$urandom_range(0, ready_bones.size() - 1)];
    endfunction

    // identity and extreme matrices, extreme vertices, ignored slots
    task automatic test_extremes();
        for (int s = 0; s < COEF_COUNT; s++)
            write_coef(0, s, (s == 0 || s == 4 || s == 8) ? Q_ONE : q_t'(0));
        write_coef(0, COEF_TRANS, 32'sh0001_8000);
        write_coef(0, COEF_TRANS + 1, -Q_ONE);
        for (int s = 0; s < COEF_COUNT; s++)
            write_coef(63, s, (s == 4 || s == COEF_TRANS + 1) ? Q_BOTTOM : Q_TOP);
        write_coef(63, COEF_TRANS + 2, q_t'(0));
        // writes to the unused slots must leave the matrix alone
        for (int s = COEF_COUNT; s < 16; s++)
            write_coef(0, s, q_t'($urandom));
        skin(0, Q_TOP, Q_BOTTOM, q_t'(0), Q_BOTTOM, Q_TOP, q_t'(-1), '1, 1'b1);
        skin(0, q_t'(0), q_t'(-1), q_t'(1), q_t'(0), q_t'(0), q_t'(0), '0, 1'b0);
        skin(63, Q_TOP, Q_TOP, Q_TOP, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM,
             64'h5555_5555_AAAA_AAAA, 1'b0);
        skin(63, Q_BOTTOM, q_t'(0), Q_TOP, Q_ONE, q_t'(-1), Q_TOP,
             64'hAAAA_AAAA_5555_5555, 1'b1);
        skin(63, q_t'(0), q_t'(0), q_t'(0), q_t'(0), q_t'(0), q_t'(0), '0, 1'b1);
    endtask

    // half scale on x: negative odd inputs must round toward minus infinity
    task automatic test_truncation();
        write_coef(0, 0, Q_HALF);
        skin(0, q_t'(-1), q_t'(0), q_t'(0), q_t'(-3), q_t'(0), q_t'(0), '0, 1'b0);
        skin(0, q_t'(1), q_t'(0), q_t'(0), q_t'(3), q_t'(0), q_t'(0), '0, 1'b0);
        skin(0, q_t'(-65537), q_t'(7), q_t'(0), Q_BOTTOM, q_t'(0), q_t'(0), '0, 1'b1);
    endtask

    // receiver stops for a long stretch while vertices keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 60; k++)
            skin_random(pick_ready_bone(), k == 59);
    endtask

    // loads, batches of vertices, rewrites and stray writes
    task automatic test_random_mix();
        int goal;
        int n;
        int bone;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        goal    = useful_beats + MIX_ITEMS;
        while (useful_beats < goal) begin
            case ($urandom_range(0, 11))
                0: write_coef($urandom_range(0, 63), $urandom_range(COEF_COUNT, 15),
                              q_t'($urandom));
                1: write_coef(pick_ready_bone(), $urandom_range(0, COEF_COUNT - 1), rand_q());
                2: begin
                    // partial load of some bone, no vertex reads it until complete
                    bone = $urandom_range(0, 63);
                    n    = $urandom_range(1, 5);
                    for (int k = 0; k < n; k++)
                        write_coef(bone, $urandom_range(0, COEF_COUNT - 1), rand_q());
                end
                3, 4: load_bone($urandom_range(0, 63), $urandom_range(0, 1));
                default: begin
                    n = $urandom_range(1, 16);
                    for (int k = 0; k < n; k++)
                        skin_random(pick_ready_bone(), k == n - 1);
                end
            endcase
        end
    endtask

    // closing stretch with both sides at full rate
    task automatic test_full_rate();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        for (int k = 0; k < 100; k++)
            skin_random(pick_ready_bone(), k % 10 == 9);
    endtask

    // receiver ready pattern
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // compare each result beat with the oldest predicted vertex
    always @(posedge aclk) begin : check_results
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_vertices.size() == 0) begin
                report_mismatch("beat with nothing pending", m_tdata[63:0], '0);
            end else begin
                want = pending_vertices.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[32 * k +: 32] !== want.pos[k])
                        report_mismatch($sformatf("pos[%0d]", k), m_tdata[32 * k +: 32],
                                        want.pos[k]);
                    if (m_tdata[96 + 32 * k +: 32] !== want.norm[k])
                        report_mismatch($sformatf("norm[%0d]", k), m_tdata[96 + 32 * k +: 32],
                                        want.norm[k]);
                end
                if (m_tdata[255:192] !== want.tex)
                    report_mismatch("tex", m_tdata[255:192], want.tex);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // stop when neither side has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_WRITE;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        for (int b = 0; b < BONE_COUNT; b++) begin
            coef_loaded[b] = '0;
            for (int s = 0; s < COEF_COUNT; s++)
                bone_coef[b][s] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_truncation();
        test_backpressure();
        test_random_mix();
        test_full_rate();
        s_tvalid <= 1'b0;

        while (pending_vertices.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d beats sent, %0d vertex results checked, %0d bones in use",
                 beats_sent, results_seen, ready_bones.size());
        $display("summary: extremes, floor rounding, saturation, long stall, %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/svs_pkg.sv
hdl/svs_ram.sv
hdl/svs_coef_store.sv
hdl/svs_transform.sv
hdl/single_bone_vertex_skinning_unit.sv
hdl/svs_checker.sv
test/tb.sv
